/* rtl/core/id3art_pkg.sv */
// Shared types and constants for the cover-art JPEG extractor.
// Holds payload structs, state and queue entry codes, tag characters.
// No dependencies.
package id3art_pkg;

	localparam logic [7:0] TAG_A = 8'h41;
	localparam logic [7:0] TAG_P = 8'h50;
	localparam logic [7:0] TAG_I = 8'h49;
	localparam logic [7:0] TAG_C = 8'h43;
	localparam logic [7:0] MARK_FF = 8'hFF;
	localparam logic [7:0] MARK_D8 = 8'hD8;

	localparam int unsigned PAYLOAD_W = 24;
	localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 24'd1500000;

	localparam logic REG_MAX_PAYLOAD = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       no_image;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_MARK,
		PH_FWD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		K_NOIMG,
		K_MARK,
		K_DATA
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		logic [7:0]  data;
		logic        last;
	} q_entry_t;

	function automatic logic [7:0] tag_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = TAG_A;
			2'd1:    c = TAG_P;
			2'd2:    c = TAG_I;
			default: c = TAG_C;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/id3art_front.sv */
// Front stage: tag and marker search, payload count, queue entry build.
// Depends on id3art_pkg.
module id3art_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  id3art_pkg::in_item_t                 item,
	input  logic [id3art_pkg::PAYLOAD_W-1:0]     max_payload,
	output logic                                 ent_push,
	output id3art_pkg::q_entry_t                 ent
);
	import id3art_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [1:0]             tag_q, tag_d;
	logic                   ff_q, ff_d;
	logic [PAYLOAD_W-1:0]   left_q, left_d;

	logic [7:0] b;
	logic       eos;
	logic       tag_hit;
	logic       mark_hit;
	logic       mark_last;
	logic       left_one;

	assign b         = item.data_byte;
	assign eos       = item.end_of_source;
	assign tag_hit   = (b == tag_char(tag_q));
	assign mark_hit  = ff_q && (b == MARK_D8);
	assign mark_last = eos || (max_payload == '0);
	assign left_one  = (left_q == PAYLOAD_W'(1));

	always_comb begin
		phase_d = phase_q;
		tag_d   = tag_q;
		ff_d    = ff_q;
		left_d  = left_q;
		unique case (phase_q)
			PH_TAG: begin
				if (tag_hit) begin
					if (tag_q == 2'd3) begin
						tag_d   = 2'd0;
						ff_d    = 1'b0;
						phase_d = PH_MARK;
					end else begin
						tag_d = tag_q + 2'd1;
					end
				end else begin
					tag_d = (b == TAG_A) ? 2'd1 : 2'd0;
				end
			end
			PH_MARK: begin
				if (mark_hit) begin
					ff_d    = 1'b0;
					left_d  = max_payload;
					phase_d = mark_last ? PH_DONE : PH_FWD;
				end else begin
					ff_d = (b == MARK_FF);
				end
			end
			PH_FWD: begin
				if (left_q != '0) begin
					left_d = left_q - PAYLOAD_W'(1);
					if (left_one)
						phase_d = PH_DONE;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		if (eos) begin
			phase_d = PH_TAG;
			tag_d   = 2'd0;
			ff_d    = 1'b0;
			left_d  = '0;
		end
	end

	always_comb begin
		ent_push  = 1'b0;
		ent.kind  = K_DATA;
		ent.data  = b;
		ent.last  = 1'b0;
		unique case (phase_q)
			PH_TAG: begin
				ent_push = accept && eos;
				ent.kind = K_NOIMG;
				ent.last = 1'b1;
			end
			PH_MARK: begin
				ent_push = accept && (mark_hit || eos);
				ent.kind = mark_hit ? K_MARK : K_NOIMG;
				ent.last = mark_hit ? mark_last : 1'b1;
			end
			PH_FWD: begin
				ent_push = accept && (left_q != '0);
				ent.kind = K_DATA;
				ent.last = eos || left_one;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= 2'd0;
			ff_q    <= 1'b0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			ff_q    <= ff_d;
			left_q  <= left_d;
		end
	end

endmodule

/* rtl/core/id3art_fifo.sv */
// Short queue of classified entries between front and back stages.
// Depends on id3art_pkg.
module id3art_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  id3art_pkg::q_entry_t  wdata,
	output logic                  full,
	input  logic                  take,
	output id3art_pkg::q_entry_t  rdata,
	output logic                  nonempty
);
	import id3art_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t      mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_take;

	assign full     = (cnt_q == FULL_CNT);
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_take  = take && nonempty;
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
			if (do_take)
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
			if (do_push && !do_take)
				cnt_q <= cnt_q + CW'(1);
			else if (do_take && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

/* rtl/core/id3art_back.sv */
// Back stage: expands queue entries into result beats, holds the output register.
// Depends on id3art_pkg.
module id3art_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  nonempty,
	input  id3art_pkg::q_entry_t  ent,
	output logic                  take,
	output logic                  empty,
	input  logic                  pop,
	output id3art_pkg::out_item_t res_item
);
	import id3art_pkg::*;

	out_item_t out_q;
	logic      vld_q;
	logic      d8_pend_q;
	logic      d8_last_q;
	logic      load;

	assign load     = !vld_q || pop;
	assign take     = load && !d8_pend_q && nonempty;
	assign empty    = !vld_q;
	assign res_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			d8_pend_q <= 1'b0;
		end else if (load) begin
			if (d8_pend_q) begin
				vld_q     <= 1'b1;
				d8_pend_q <= 1'b0;
			end else begin
				vld_q     <= nonempty;
				d8_pend_q <= nonempty && (ent.kind == K_MARK);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (d8_pend_q) begin
				out_q <= '{out_byte: MARK_D8, is_last: d8_last_q, no_image: 1'b0};
			end else if (nonempty) begin
				d8_last_q <= ent.last;
				case (ent.kind)
					K_NOIMG: out_q <= '{out_byte: 8'h00, is_last: 1'b1, no_image: 1'b1};
					K_MARK:  out_q <= '{out_byte: MARK_FF, is_last: 1'b0, no_image: 1'b0};
					default: out_q <= '{out_byte: ent.data, is_last: ent.last, no_image: 1'b0};
				endcase
			end
		end
	end

endmodule

/* rtl/core/id3_art_jpeg_extractor_top.sv */
// Top level of the cover-art JPEG extractor: config register, front, queue, back.
// Depends on id3art_pkg, id3art_front, id3art_fifo, id3art_back.
//
// Usage:
//   Input queue port: src_item (data_byte, end_of_source) is taken on push && !full.
//   Result queue port: res_item is valid while empty is low, taken on pop.
//   APB port: max_payload at byte address 0 (24 bits, reset 1500000).
// Bytes are matched against the APIC tag, then the FF D8 marker; on the marker
// two beats (FF, D8) are produced, then up to max_payload forwarded bytes.
// An end_of_source byte before the marker gives one no_image beat.
// With the queue empty, a byte's result entry is written into the queue at the
// edge that takes the byte, then loaded into the output register. Throughput:
// one byte per cycle while full is low; the marker yields two beats, which the back
// stage sends in turn, FF then D8, while the queue (QUEUE_DEPTH) absorbs the extra beat.
// Reset: search state returns to tag search, queue and output empty,
// max_payload back to its reset value.
// Stall: while pop is low the output beat holds; the queue then fills and full
// rises, holding the source.
module id3_art_jpeg_extractor_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  id3art_pkg::in_item_t  src_item,
	output logic                  empty,
	input  logic                  pop,
	output id3art_pkg::out_item_t res_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import id3art_pkg::*;

	logic [PAYLOAD_W-1:0] max_payload_q;
	logic                 accept;
	logic                 ent_push;
	q_entry_t             ent_w;
	q_entry_t             ent_r;
	logic                 nonempty;
	logic                 take;

	assign pready = 1'b1;
	assign accept = push && !full;
	assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {{(32-PAYLOAD_W){1'b0}}, max_payload_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
			max_payload_q <= pwdata[PAYLOAD_W-1:0];
		end
	end

	id3art_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (src_item),
		.max_payload (max_payload_q),
		.ent_push    (ent_push),
		.ent         (ent_w)
	);

	id3art_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ent_push),
		.wdata    (ent_w),
		.full     (full),
		.take     (take),
		.rdata    (ent_r),
		.nonempty (nonempty)
	);

	id3art_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.ent      (ent_r),
		.take     (take),
		.empty    (empty),
		.pop      (pop),
		.res_item (res_item)
	);

endmodule
